>>> sv/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and constants for the mecanum wheel mixer
// Payload structs, register indexes, direction codes and reset values.
// ----------------------------------------------------------------------------
package mwm_pkg;

	localparam int RAW_W    = 8;
	localparam int BAND_W   = 7;
	localparam int GAIN_W   = 16;
	localparam int DUTY_W   = 15;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int GAIN_SHIFT = 14;  // turn gain is always Q2.14

	localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN    = 2'd2;

	localparam logic [RAW_W-1:0]  RST_STICK_CENTER = 8'd128;
	localparam logic [BAND_W-1:0] RST_DEAD_BAND    = 7'd10;
	localparam logic [GAIN_W-1:0] RST_TURN_GAIN    = 16'd16384;

	localparam logic [RAW_W-1:0]  RAW_MAX = 8'd255;

	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	typedef struct packed {
		logic [RAW_W-1:0] forward_raw;
		logic [RAW_W-1:0] sideways_raw;
		logic [RAW_W-1:0] turn_raw;
	} in_t;

	typedef struct packed {
		logic [1:0]        wheel0_dir;
		logic [DUTY_W-1:0] wheel0_duty;
		logic [1:0]        wheel1_dir;
		logic [DUTY_W-1:0] wheel1_duty;
		logic [1:0]        wheel2_dir;
		logic [DUTY_W-1:0] wheel2_duty;
		logic [1:0]        wheel3_dir;
		logic [DUTY_W-1:0] wheel3_duty;
	} out_t;

endpackage

>>> sv/mwm_frac_div.sv
// ----------------------------------------------------------------------------
// mwm_frac_div: pipelined restoring fraction divider
// Computes floor(num * 2^(STEPS-1) / den) for num <= den, one quotient bit
// per register stage. A sign bit rides along with the data.
// ----------------------------------------------------------------------------
module mwm_frac_div #(
	parameter int W     = 8,
	parameter int STEPS = 15
) (
	input  logic             clk,
	input  logic             en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	input  logic             neg,
	output logic [STEPS-1:0] quo,
	output logic             quo_neg
);

	logic [W-1:0]     rem_s [STEPS];
	logic [W-1:0]     den_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];
	logic             neg_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [W:0]       x;
		logic [W:0]       r;
		logic             ge;
		logic [W-1:0]     den_in;
		logic [STEPS-1:0] q_in;
		logic             neg_in;

		if (i == 0) begin : g_first
			assign x      = {1'b0, num};
			assign den_in = den;
			assign q_in   = '0;
			assign neg_in = neg;
		end else begin : g_next
			assign x      = {rem_s[i-1], 1'b0};
			assign den_in = den_s[i-1];
			assign q_in   = quo_s[i-1];
			assign neg_in = neg_s[i-1];
		end

		assign ge = (x >= {1'b0, den_in});
		assign r  = ge ? (x - {1'b0, den_in}) : x;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= r[W-1:0];
				den_s[i] <= den_in;
				quo_s[i] <= {q_in[STEPS-2:0], ge};
				neg_s[i] <= neg_in;
			end
		end
	end

	assign quo     = quo_s[STEPS-1];
	assign quo_neg = neg_s[STEPS-1];

endmodule

>>> sv/mwm_axis_map.sv
// ----------------------------------------------------------------------------
// mwm_axis_map: joystick deadzone mapping for one axis
// Registers the deadzone numerator and span, then divides to a magnitude in
// 0..ONE with a separate sign (below center is positive).
// ----------------------------------------------------------------------------
module mwm_axis_map
	import mwm_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              en,
	input  logic [RAW_W-1:0]  raw,
	input  logic [RAW_W-1:0]  center,
	input  logic [BAND_W-1:0] dband,
	output logic [FRAC_BITS:0] mag,
	output logic              neg
);

	localparam int QW = FRAC_BITS + 1;

	logic [RAW_W+1:0] c_w, r_w, d_w, m_w;
	logic             above, below;
	logic [RAW_W+1:0] n_w, den_w;
	logic [RAW_W-1:0] n_s1, den_s1;
	logic             neg_s1;

	always_comb begin
		c_w   = {2'b00, center};
		r_w   = {2'b00, raw};
		d_w   = {3'b000, dband};
		m_w   = {2'b00, RAW_MAX};
		above = (r_w + d_w) < c_w;   // stick pushed toward positive
		below = r_w > (c_w + d_w);
		priority if (above) begin
			n_w   = c_w - r_w - d_w;
			den_w = c_w - d_w;
		end else if (below) begin
			n_w   = r_w - c_w - d_w;
			den_w = m_w - c_w - d_w;
		end else begin
			n_w   = '0;
			den_w = {{(RAW_W+1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= n_w[RAW_W-1:0];
			den_s1 <= den_w[RAW_W-1:0];
			neg_s1 <= below;
		end
	end

	mwm_frac_div #(.W(RAW_W), .STEPS(QW)) u_div (
		.clk     (clk),
		.en      (en),
		.num     (n_s1),
		.den     (den_s1),
		.neg     (neg_s1),
		.quo     (mag),
		.quo_neg (neg)
	);

endmodule

>>> sv/mecanum_wheel_mixer_core.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_core: joystick to four mecanum wheel drive commands
// Throughput: one transaction per cycle while the output is not stalled;
// most of the depth comes from the two ranks of restoring dividers,
// which resolve one quotient bit per stage.
// Reset: config returns to center 128, band 10, gain 16384; pipe empties.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_core
	import mwm_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data
);

	localparam int QW  = FRAC_BITS + 1;
	localparam int PW  = QW + GAIN_W;
	localparam int TW  = PW - GAIN_SHIFT;
	localparam int WS  = FRAC_BITS + 5;
	localparam int WM  = WS - 1;
	localparam int LAT = 2 * QW + 5;
	localparam logic [WM-1:0] ONE = WM'(1) << FRAC_BITS;

	logic [RAW_W-1:0]  center_q;
	logic [BAND_W-1:0] band_q;
	logic [GAIN_W-1:0] gain_q;

	logic [LAT-1:0] vld_q;
	logic           en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= RST_STICK_CENTER;
			band_q   <= RST_DEAD_BAND;
			gain_q   <= RST_TURN_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_STICK_CENTER: center_q <= cfg_wdata[RAW_W-1:0];
				CFG_DEAD_BAND:    band_q   <= cfg_wdata[BAND_W-1:0];
				CFG_TURN_GAIN:    gain_q   <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves together unless the output holds a stalled result
	assign en       = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// axis mapping
	logic [QW-1:0] f_mag, s_mag, t_mag;
	logic          f_neg, s_neg, t_neg;

	mwm_axis_map #(.FRAC_BITS(FRAC_BITS)) u_fwd (
		.clk(clk), .en(en), .raw(in_data.forward_raw), .center(center_q),
		.dband(band_q), .mag(f_mag), .neg(f_neg));
	mwm_axis_map #(.FRAC_BITS(FRAC_BITS)) u_side (
		.clk(clk), .en(en), .raw(in_data.sideways_raw), .center(center_q),
		.dband(band_q), .mag(s_mag), .neg(s_neg));
	mwm_axis_map #(.FRAC_BITS(FRAC_BITS)) u_turn (
		.clk(clk), .en(en), .raw(in_data.turn_raw), .center(center_q),
		.dband(band_q), .mag(t_mag), .neg(t_neg));

	// gain multiply stage
	logic signed [QW:0] f_sv, s_sv;
	logic signed [QW:0] f_m, s_m;
	logic [PW-1:0]      tp_m;
	logic               tn_m;

	assign f_sv = f_neg ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
	assign s_sv = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

	always_ff @(posedge clk) begin
		if (en) begin
			f_m  <= f_sv;
			s_m  <= s_sv;
			tp_m <= PW'(t_mag) * PW'(gain_q);
			tn_m <= t_neg;
		end
	end

	// wheel term stage
	logic [TW-1:0]      t_u;
	logic signed [WS-1:0] t_sv, sum_p, sum_m, half_p, half_m;
	logic signed [WS-1:0] w_x [4];

	always_comb begin
		t_u    = tp_m[PW-1:GAIN_SHIFT];
		t_sv   = tn_m ? -$signed(WS'({1'b0, t_u})) : $signed(WS'({1'b0, t_u}));
		sum_p  = WS'(f_m) + WS'(s_m);
		sum_m  = WS'(f_m) - WS'(s_m);
		// halve rounding toward zero
		half_p = (sum_p + $signed(WS'(sum_p[WS-1]))) >>> 1;
		half_m = (sum_m + $signed(WS'(sum_m[WS-1]))) >>> 1;
	end

	logic signed [WS-1:0] w_w [4];

	always_ff @(posedge clk) begin
		if (en) begin
			w_w[0] <= half_p - t_sv;
			w_w[1] <= half_m - t_sv;
			w_w[2] <= half_m + t_sv;
			w_w[3] <= half_p + t_sv;
		end
	end

	// magnitude and largest-term stage
	logic [WM-1:0] mag_x [4];
	logic [WM-1:0] big_x;

	always_comb begin
		big_x = ONE;
		for (int k = 0; k < 4; k++) begin
			mag_x[k] = w_w[k][WS-1] ? WM'(-w_w[k]) : WM'(w_w[k]);
			if (mag_x[k] > big_x) big_x = mag_x[k];
		end
		for (int k = 0; k < 4; k++) w_x[k] = w_w[k];
	end

	logic [WM-1:0] mag_n [4];
	logic          neg_n [4];
	logic [WM-1:0] big_n;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				mag_n[k] <= mag_x[k];
				neg_n[k] <= w_x[k][WS-1];
			end
			big_n <= big_x;
		end
	end

	// normalization: term * ONE / largest; exact when largest is ONE
	logic [QW-1:0] q_n [4];
	logic          qn_n [4];
	logic [1:0]    dir_n [4];
	logic [DUTY_W-1:0] duty_n [4];

	for (genvar k = 0; k < 4; k++) begin : g_wheel
		mwm_frac_div #(.W(WM), .STEPS(QW)) u_norm (
			.clk     (clk),
			.en      (en),
			.num     (mag_n[k]),
			.den     (big_n),
			.neg     (neg_n[k]),
			.quo     (q_n[k]),
			.quo_neg (qn_n[k])
		);

		always_comb begin
			priority if (q_n[k] == '0) dir_n[k] = DIR_OFF;
			else if (qn_n[k])          dir_n[k] = DIR_REV;
			else                       dir_n[k] = DIR_FWD;
			duty_n[k] = DUTY_W'(q_n[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.wheel0_dir  <= dir_n[0];
			out_data.wheel0_duty <= duty_n[0];
			out_data.wheel1_dir  <= dir_n[1];
			out_data.wheel1_duty <= duty_n[1];
			out_data.wheel2_dir  <= dir_n[2];
			out_data.wheel2_duty <= duty_n[2];
			out_data.wheel3_dir  <= dir_n[3];
			out_data.wheel3_duty <= duty_n[3];
		end
	end

	assign out_valid = vld_q[LAT-1];

endmodule
